// ===== rtl/dhkv_pkg.sv =====
package dhkv_pkg;

    localparam int INDEX_BITS      = 10;
    localparam int LOSE_BITS       = 3;
    localparam int HALF_WORD_SHIFT = 32;
    localparam int KEY_BITS        = 64;

    localparam int WORD_BITS  = 64;
    localparam int COUNT_BITS = 11;
    localparam int SLOTS      = 1 << INDEX_BITS;

    localparam logic [COUNT_BITS-1:0] LOAD_LIMIT_RESET = COUNT_BITS'(512);

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_SET    = 1'b1;

    typedef logic [INDEX_BITS-1:0] slot_t;
    typedef logic [KEY_BITS-1:0]   key_t;
    typedef logic [WORD_BITS-1:0]  word_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK
    } state_t;

    // Write request from the sequencer to the slot stores.
    typedef struct packed {
        logic  key_we;
        logic  val_we;
        slot_t addr;
        key_t  key;
        word_t value;
    } tbl_wr_t;

    typedef struct packed {
        logic  hit;
        word_t data;
        logic  refused;
    } result_t;

    function automatic slot_t first_hash(key_t k);
        key_t mixed;
        mixed = (k >> LOSE_BITS) ^ (k >> (2 * LOSE_BITS));
        return mixed[INDEX_BITS-1:0];
    endfunction

    // The step is forced odd so that it visits every slot of the table.
    function automatic slot_t second_hash(key_t k);
        key_t mixed;
        mixed = (k >> LOSE_BITS) ^ (k >> HALF_WORD_SHIFT);
        return mixed[INDEX_BITS-1:0] | slot_t'(1);
    endfunction

endpackage

// ===== rtl/dhkv_if.sv =====
interface dhkv_req_if;
    logic                           valid;
    logic                           ready;
    logic                           op;
    logic [dhkv_pkg::WORD_BITS-1:0] key;
    logic [dhkv_pkg::WORD_BITS-1:0] value;

    modport source (output valid, output op, output key, output value, input ready);
    modport sink   (input valid, input op, input key, input value, output ready);
endinterface

interface dhkv_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           hit;
    logic [dhkv_pkg::WORD_BITS-1:0] data;
    logic                           refused;

    modport source (output valid, output hit, output data, output refused, input ready);
    modport sink   (input valid, input hit, input data, input refused, output ready);
endinterface

interface dhkv_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [dhkv_pkg::COUNT_BITS-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/dhkv_table.sv =====
module dhkv_table (
    input  logic              clk,
    input  dhkv_pkg::tbl_wr_t wr,
    input  dhkv_pkg::slot_t   rd_addr,
    output dhkv_pkg::key_t    rd_key,
    output dhkv_pkg::word_t   rd_value
);

    dhkv_pkg::key_t  key_mem [dhkv_pkg::SLOTS];
    dhkv_pkg::word_t val_mem [dhkv_pkg::SLOTS];

    dhkv_pkg::key_t  rd_key_reg;
    dhkv_pkg::word_t rd_value_reg;

    always_ff @(posedge clk)
    begin
        if (wr.key_we)
        begin
            key_mem[wr.addr] <= wr.key;
        end
        rd_key_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.val_we)
        begin
            val_mem[wr.addr] <= wr.value;
        end
        rd_value_reg <= val_mem[rd_addr];
    end

    assign rd_key   = rd_key_reg;
    assign rd_value = rd_value_reg;

endmodule

// ===== rtl/dhkv_ctrl.sv =====
module dhkv_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    dhkv_req_if.sink           req,
    input  dhkv_pkg::count_t   load_limit,
    input  logic               out_free,
    input  dhkv_pkg::key_t     rd_key,
    input  dhkv_pkg::word_t    rd_value,
    output dhkv_pkg::slot_t    rd_addr,
    output dhkv_pkg::tbl_wr_t  tbl_wr,
    output logic               res_valid,
    output dhkv_pkg::result_t  res
);

    dhkv_pkg::state_t state_reg, state_next;

    logic             op_reg,    op_next;
    dhkv_pkg::key_t   key_reg,   key_next;
    dhkv_pkg::word_t  value_reg, value_next;
    dhkv_pkg::slot_t  addr_reg,  addr_next;
    dhkv_pkg::slot_t  step_reg,  step_next;
    dhkv_pkg::slot_t  count_reg, count_next;
    dhkv_pkg::slot_t  clr_reg,   clr_next;
    dhkv_pkg::count_t used_reg,  used_next;

    logic key_zero;
    logic key_match;
    logic slot_empty;
    logic probe_last;
    logic probe_done;
    logic at_limit;
    logic claim;

    assign key_zero   = (key_reg == '0);
    assign key_match  = (rd_key == key_reg);
    assign slot_empty = (rd_key == '0);
    assign probe_last = (count_reg == '1);
    assign probe_done = key_zero || key_match || slot_empty || probe_last;
    assign at_limit   = (used_reg >= load_limit);
    assign claim      = (state_reg == dhkv_pkg::ST_CHECK) && out_free && !key_zero
                        && !key_match && slot_empty && (op_reg == dhkv_pkg::OP_SET)
                        && !at_limit;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dhkv_pkg::ST_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = dhkv_pkg::ST_IDLE;
                end
            end
            dhkv_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = dhkv_pkg::ST_READ;
                end
            end
            dhkv_pkg::ST_READ:
            begin
                state_next = dhkv_pkg::ST_CHECK;
            end
            dhkv_pkg::ST_CHECK:
            begin
                if (!probe_done)
                begin
                    state_next = dhkv_pkg::ST_READ;
                end
                else if (out_free)
                begin
                    state_next = dhkv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dhkv_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        req.ready    = (state_reg == dhkv_pkg::ST_IDLE);
        rd_addr      = addr_reg;
        tbl_wr       = '0;
        tbl_wr.addr  = addr_reg;
        tbl_wr.key   = key_reg;
        tbl_wr.value = value_reg;
        res_valid    = 1'b0;
        res          = '0;

        op_next    = op_reg;
        key_next   = key_reg;
        value_next = value_reg;
        addr_next  = addr_reg;
        step_next  = step_reg;
        count_next = count_reg;
        clr_next   = clr_reg;
        used_next  = used_reg;

        unique case (state_reg)
            dhkv_pkg::ST_CLEAR:
            begin
                tbl_wr.key_we = 1'b1;
                tbl_wr.addr   = clr_reg;
                tbl_wr.key    = '0;
                clr_next      = clr_reg + dhkv_pkg::slot_t'(1);
            end
            dhkv_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.op;
                    key_next   = req.key[dhkv_pkg::KEY_BITS-1:0];
                    value_next = req.value;
                    addr_next  = dhkv_pkg::first_hash(req.key[dhkv_pkg::KEY_BITS-1:0]);
                    step_next  = dhkv_pkg::second_hash(req.key[dhkv_pkg::KEY_BITS-1:0]);
                    count_next = '0;
                end
            end
            dhkv_pkg::ST_READ:
            begin
            end
            dhkv_pkg::ST_CHECK:
            begin
                if (!probe_done)
                begin
                    addr_next  = addr_reg + step_reg;
                    count_next = count_reg + dhkv_pkg::slot_t'(1);
                end
                else if (out_free)
                begin
                    res_valid = 1'b1;
                    if (key_zero)
                    begin
                        res.refused = 1'b1;
                    end
                    else if (key_match)
                    begin
                        res.hit       = 1'b1;
                        res.data      = rd_value;
                        tbl_wr.val_we = (op_reg == dhkv_pkg::OP_SET);
                    end
                    else if (op_reg == dhkv_pkg::OP_SET)
                    begin
                        // An empty slot under the limit is claimed; anything else refuses.
                        if (claim)
                        begin
                            tbl_wr.key_we = 1'b1;
                            tbl_wr.val_we = 1'b1;
                            used_next     = used_reg + dhkv_pkg::count_t'(1);
                        end
                        else
                        begin
                            res.refused = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dhkv_pkg::ST_CLEAR;
            clr_reg   <= '0;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        value_reg <= value_next;
        addr_reg  <= addr_next;
        step_reg  <= step_next;
        count_reg <= count_next;
    end

    a_claim_counts: assert property (@(posedge clk) disable iff (!rst_n)
        claim |=> used_reg == $past(used_reg) + dhkv_pkg::count_t'(1))
        else $error("used count did not follow a claimed slot");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        (tbl_wr.key_we || tbl_wr.val_we) |->
        (state_reg == dhkv_pkg::ST_CHECK || state_reg == dhkv_pkg::ST_CLEAR))
        else $error("table written outside of a probe check or the clearing pass");

    a_hit_not_refused: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res.hit && res.refused))
        else $error("result both hit and refused");

    a_claim_under_limit: assert property (@(posedge clk) disable iff (!rst_n)
        claim |-> used_reg < load_limit)
        else $error("slot claimed at the load limit");

endmodule

// ===== rtl/double_hash_key_value_map_core.sv =====
// Each request probes the slot table through one shared read-and-compare step.
// A request probes P slots one after another, where P runs from 1 to 1024; each
// probe is one key/value memory read plus one compare. A new request is taken
// only after the result of the last one has been handed to the response register.
// After reset the key memory is cleared one slot a cycle, so no request is taken
// until every slot has been cleared; configuration writes are taken at any time.
module double_hash_key_value_map_core (
    input  logic       clk,
    input  logic       rst_n,
    dhkv_cfg_if.sink   cfg,
    dhkv_req_if.sink   req,
    dhkv_rsp_if.source rsp
);

    dhkv_pkg::count_t  load_limit_reg;
    logic              rsp_valid_reg, rsp_valid_next;
    dhkv_pkg::result_t rsp_reg;

    dhkv_pkg::slot_t   rd_addr;
    dhkv_pkg::key_t    rd_key;
    dhkv_pkg::word_t   rd_value;
    dhkv_pkg::tbl_wr_t tbl_wr;
    logic              res_valid;
    dhkv_pkg::result_t res;
    logic              out_free;

    assign cfg.ready = 1'b1;
    assign out_free  = !rsp_valid_reg || rsp.ready;

    dhkv_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .load_limit (load_limit_reg),
        .out_free   (out_free),
        .rd_key     (rd_key),
        .rd_value   (rd_value),
        .rd_addr    (rd_addr),
        .tbl_wr     (tbl_wr),
        .res_valid  (res_valid),
        .res        (res)
    );

    dhkv_table u_table (
        .clk      (clk),
        .wr       (tbl_wr),
        .rd_addr  (rd_addr),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_valid)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_limit_reg <= dhkv_pkg::LOAD_LIMIT_RESET;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                load_limit_reg <= cfg.data;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.hit     = rsp_reg.hit;
    assign rsp.data    = rsp_reg.data;
    assign rsp.refused = rsp_reg.refused;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready) |-> !res_valid)
        else $error("new result while the held beat was not taken");

    a_refused_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.refused) |-> (res.data == '0 && !res.hit))
        else $error("refused result carries data");

    a_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !req.ready)
        else $error("result produced while idle");

endmodule
